[rtl/wpq_pkg.sv]
package wpq_pkg;

   // operation codes on req_op
   localparam logic [2:0] OP_ENQUEUE = 3'd0;
   localparam logic [2:0] OP_DEQUEUE = 3'd1;
   localparam logic [2:0] OP_PEEK    = 3'd2;
   localparam logic [2:0] OP_REMOVE  = 3'd3;
   localparam logic [2:0] OP_LIST    = 3'd4;

   // result status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_EMPTY     = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [1:0] STAT_FULL      = 2'd3;

   // burst limit and streak counter
   localparam int         BURST_W     = 4;
   localparam logic [3:0] BURST_RESET = 4'd2;
   localparam logic [3:0] STREAK_MAX  = 4'd15;

   // listing length cap and its counter width
   localparam int MAX_RESULTS = 32;
   localparam int KW          = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LIST,
      S_RESTORE
   } state_type;

   // operation applied to a whole row of cells
   typedef enum logic [2:0] {
      ROW_HOLD,
      ROW_PUSH,
      ROW_POP,
      ROW_REMOVE,
      ROW_ROTATE
   } row_op_type;

   // what one cell loads this cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_NEXT,
      CELL_HEAD
   } cell_cmd_type;

   // row status back to the controller
   typedef struct packed {
      logic hit;
      logic empty;
   } row_stat_type;

   // class picked for service: 1 high-priority, 0 general
   function automatic logic pick_high(input logic [BURST_W-1:0] strk,
                                      input logic [BURST_W-1:0] limit,
                                      input logic have_pri,
                                      input logic have_gen);
      logic sel;
      if (strk >= limit) begin
         sel = !have_gen;
      end else begin
         sel = have_pri;
      end
      return sel;
   endfunction

endpackage

[rtl/two_class_weighted_priority_queue.sv]
// Two-class client queue with weighted service: a high-priority queue and a general queue,
// each QUEUE_DEPTH identifiers deep, held in rows of cells that shift toward the head.
// Service takes high-priority clients first until csr_write_data's burst limit is met,
// then a waiting general client. Enqueue, dequeue, peek and remove take the request in
// S_IDLE, then let the cell rows compare and shift in S_EXEC, with any wait on rsp_ready
// spent in S_EXEC. A listing takes the request in S_IDLE and sets up in S_EXEC, then
// lists the clients in S_LIST (at most 32), each one held while it waits on rsp_ready,
// then the rows rotate back to their order in S_RESTORE until each row has turned fully.
// A new request is taken only while the block is idle; a finished result may still be
// waiting on rsp_ready.
module two_class_weighted_priority_queue #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_WIDTH    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_op,
   input  logic [ID_WIDTH-1:0] req_client_id,
   input  logic                req_is_elderly,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [ID_WIDTH-1:0] rsp_out_client,
   output logic                rsp_out_elderly,
   output logic                rsp_last,
   input  logic                csr_write_enable,
   input  logic [3:0]          csr_write_data
);
   import wpq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = (CW + 1 > KW) ? CW + 1 : KW;

   state_type state_ff, state_in;

   logic [2:0]          op_ff;
   logic [ID_WIDTH-1:0] id_ff;
   logic                cls_ff;
   logic [BURST_W-1:0]  burst_ff;
   logic [BURST_W-1:0]  streak_ff, streak_in;
   logic [BURST_W-1:0]  lstreak_ff, lstreak_in;
   logic [CW-1:0]       pi_ff, pi_in, gi_ff, gi_in;
   logic [KW-1:0]       k_ff, k_in, total_ff, total_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [ID_WIDTH-1:0] rsp_client_ff, rsp_client_in;
   logic                rsp_elderly_ff, rsp_elderly_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_load;

   row_op_type          pri_op, gen_op;
   row_stat_type        pri_stat, gen_stat;
   logic [ID_WIDTH-1:0] pri_head, gen_head;
   logic [CW-1:0]       pri_count, gen_count;

   logic                slot_free, op_known, both_empty, list_go, list_last;
   logic                serve_sel, list_sel, pri_left, gen_left, restore_done;
   logic [SW-1:0]       sum_w;

   // cell rows
   wpq_row #(.DEPTH(QUEUE_DEPTH), .ID_W(ID_WIDTH), .CW(CW)) u_pri (
      .clock   (clock),
      .reset   (reset),
      .op      (pri_op),
      .push_id (id_ff),
      .target  (id_ff),
      .head    (pri_head),
      .count   (pri_count),
      .stat    (pri_stat)
   );

   wpq_row #(.DEPTH(QUEUE_DEPTH), .ID_W(ID_WIDTH), .CW(CW)) u_gen (
      .clock   (clock),
      .reset   (reset),
      .op      (gen_op),
      .push_id (id_ff),
      .target  (id_ff),
      .head    (gen_head),
      .count   (gen_count),
      .stat    (gen_stat)
   );

   // shared decode
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign op_known     = op_ff inside {[OP_ENQUEUE:OP_LIST]};
   assign both_empty   = pri_stat.empty && gen_stat.empty;
   assign list_go      = (op_ff == OP_LIST) && !both_empty;
   assign serve_sel    = pick_high(streak_ff, burst_ff, !pri_stat.empty, !gen_stat.empty);
   assign pri_left     = pi_ff < pri_count;
   assign gen_left     = gi_ff < gen_count;
   assign list_sel     = pick_high(lstreak_ff, burst_ff, pri_left, gen_left);
   assign list_last    = (k_ff + KW'(1)) == total_ff;
   assign restore_done = !pri_left && !gen_left;
   assign sum_w        = SW'(pri_count) + SW'(gen_count);
   assign req_ready    = (state_ff == S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (!op_known) begin
               state_in = S_IDLE;
            end else if (slot_free) begin
               state_in = list_go ? S_LIST : S_IDLE;
            end
         end
         S_LIST: begin
            if (slot_free && list_last) state_in = S_RESTORE;
         end
         S_RESTORE: begin
            if (restore_done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath control and result generation
   always_comb begin
      pri_op         = ROW_HOLD;
      gen_op         = ROW_HOLD;
      rsp_load       = 1'b0;
      rsp_status_in  = STAT_OK;
      rsp_client_in  = '0;
      rsp_elderly_in = 1'b0;
      rsp_last_in    = 1'b1;
      streak_in      = streak_ff;
      lstreak_in     = lstreak_ff;
      pi_in          = pi_ff;
      gi_in          = gi_ff;
      k_in           = k_ff;
      total_in       = total_ff;
      case (state_ff)
         S_EXEC: begin
            if (slot_free) begin
               case (op_ff)
                  OP_ENQUEUE: begin
                     rsp_load = 1'b1;
                     if (cls_ff) begin
                        if (pri_count == CW'(QUEUE_DEPTH)) begin
                           rsp_status_in = STAT_FULL;
                        end else begin
                           pri_op = ROW_PUSH;
                        end
                     end else begin
                        if (gen_count == CW'(QUEUE_DEPTH)) begin
                           rsp_status_in = STAT_FULL;
                        end else begin
                           gen_op = ROW_PUSH;
                        end
                     end
                  end
                  OP_DEQUEUE, OP_PEEK: begin
                     rsp_load = 1'b1;
                     if (both_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_client_in  = serve_sel ? pri_head : gen_head;
                        rsp_elderly_in = serve_sel;
                        if (op_ff == OP_DEQUEUE) begin
                           if (serve_sel) begin
                              pri_op = ROW_POP;
                              if (streak_ff != STREAK_MAX) streak_in = streak_ff + 4'd1;
                           end else begin
                              gen_op    = ROW_POP;
                              streak_in = '0;
                           end
                        end
                     end
                  end
                  OP_REMOVE: begin
                     rsp_load = 1'b1;
                     if (pri_stat.hit) begin
                        pri_op = ROW_REMOVE;
                     end else if (gen_stat.hit) begin
                        gen_op = ROW_REMOVE;
                     end else begin
                        rsp_status_in = STAT_NOT_FOUND;
                     end
                  end
                  OP_LIST: begin
                     if (both_empty) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        pi_in      = '0;
                        gi_in      = '0;
                        k_in       = '0;
                        lstreak_in = streak_ff;
                        if (sum_w > SW'(MAX_RESULTS)) begin
                           total_in = KW'(MAX_RESULTS);
                        end else begin
                           total_in = sum_w[KW-1:0];
                        end
                     end
                  end
                  default: rsp_load = 1'b0;
               endcase
            end
         end
         S_LIST: begin
            if (slot_free) begin
               rsp_load       = 1'b1;
               rsp_client_in  = list_sel ? pri_head : gen_head;
               rsp_elderly_in = list_sel;
               rsp_last_in    = list_last;
               k_in           = k_ff + KW'(1);
               if (list_sel) begin
                  pri_op = ROW_ROTATE;
                  pi_in  = pi_ff + CW'(1);
                  if (lstreak_ff != STREAK_MAX) lstreak_in = lstreak_ff + 4'd1;
               end else begin
                  gen_op     = ROW_ROTATE;
                  gi_in      = gi_ff + CW'(1);
                  lstreak_in = '0;
               end
            end
         end
         S_RESTORE: begin
            // finish the rotations so each row is back in service order
            if (pri_left) begin
               pri_op = ROW_ROTATE;
               pi_in  = pi_ff + CW'(1);
            end
            if (gen_left) begin
               gen_op = ROW_ROTATE;
               gi_in  = gi_ff + CW'(1);
            end
         end
         default: rsp_load = 1'b0;
      endcase
   end

   // result register
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         streak_ff    <= '0;
         burst_ff     <= BURST_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         streak_ff    <= streak_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) burst_ff <= csr_write_data;
      end
   end

   // request capture, listing counters and result payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff  <= req_op;
         id_ff  <= req_client_id;
         cls_ff <= req_is_elderly;
      end
      lstreak_ff <= lstreak_in;
      pi_ff      <= pi_in;
      gi_ff      <= gi_in;
      k_ff       <= k_in;
      total_ff   <= total_in;
      if (rsp_load) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_client_ff  <= rsp_client_in;
         rsp_elderly_ff <= rsp_elderly_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_client  = rsp_client_ff;
   assign rsp_out_elderly = rsp_elderly_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

[rtl/wpq_cell.sv]
module wpq_cell #(
   parameter int ID_W = 16
) (
   input  logic                  clock,
   input  wpq_pkg::cell_cmd_type cmd,
   input  logic                  occupied,
   input  logic [ID_W-1:0]       load_id,
   input  logic [ID_W-1:0]       next_id,
   input  logic [ID_W-1:0]       head_id,
   input  logic [ID_W-1:0]       target,
   output logic [ID_W-1:0]       data,
   output logic                  match
);
   import wpq_pkg::*;

   logic [ID_W-1:0] data_ff, data_in;

   // pick the new contents of this cell
   always_comb begin
      case (cmd)
         CELL_LOAD: data_in = load_id;
         CELL_NEXT: data_in = next_id;
         CELL_HEAD: data_in = head_id;
         default:   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // identifier compare for removal
   assign match = occupied && (data_ff == target);
   assign data  = data_ff;

endmodule

[rtl/wpq_row.sv]
module wpq_row #(
   parameter int DEPTH = 16,
   parameter int ID_W  = 16,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wpq_pkg::row_op_type   op,
   input  logic [ID_W-1:0]       push_id,
   input  logic [ID_W-1:0]       target,
   output logic [ID_W-1:0]       head,
   output logic [CW-1:0]         count,
   output wpq_pkg::row_stat_type stat
);
   import wpq_pkg::*;

   logic [CW-1:0]   count_ff, count_in;
   logic [ID_W-1:0] data [DEPTH];
   logic [DEPTH-1:0] match;
   logic [DEPTH:0]   seen;
   cell_cmd_type     cmd [DEPTH];

   // first-match chain: a cell at or after the first match shifts toward the head
   assign seen[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ID_W-1:0] next_id;
      logic            occupied;

      assign occupied    = CW'(i) < count_ff;
      assign seen[i + 1] = seen[i] | match[i];

      if (i == DEPTH - 1) begin : g_tail
         assign next_id = data[i];
      end else begin : g_mid
         assign next_id = data[i + 1];
      end

      // per-cell command decode
      always_comb begin
         cmd[i] = CELL_HOLD;
         case (op)
            ROW_PUSH: begin
               if (CW'(i) == count_ff) cmd[i] = CELL_LOAD;
            end
            ROW_POP: begin
               cmd[i] = CELL_NEXT;
            end
            ROW_REMOVE: begin
               if (seen[i] || match[i]) cmd[i] = CELL_NEXT;
            end
            ROW_ROTATE: begin
               if (CW'(i + 1) == count_ff) begin
                  cmd[i] = CELL_HEAD;
               end else if (occupied) begin
                  cmd[i] = CELL_NEXT;
               end
            end
            default: cmd[i] = CELL_HOLD;
         endcase
      end

      wpq_cell #(.ID_W(ID_W)) u_cell (
         .clock    (clock),
         .cmd      (cmd[i]),
         .occupied (occupied),
         .load_id  (push_id),
         .next_id  (next_id),
         .head_id  (data[0]),
         .target   (target),
         .data     (data[i]),
         .match    (match[i])
      );
   end

   // fill count
   always_comb begin
      count_in = count_ff;
      case (op)
         ROW_PUSH:   count_in = count_ff + CW'(1);
         ROW_POP:    count_in = count_ff - CW'(1);
         ROW_REMOVE: if (seen[DEPTH]) count_in = count_ff - CW'(1);
         default:    count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head       = data[0];
   assign count      = count_ff;
   assign stat.hit   = seen[DEPTH];
   assign stat.empty = (count_ff == '0);

endmodule

[rtl/wpq_checker.sv]
module wpq_props #(
   parameter int ID_WIDTH = 16
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [1:0]          rsp_status,
   input logic [ID_WIDTH-1:0] rsp_out_client,
   input logic                rsp_out_elderly,
   input logic                rsp_last
);
   import wpq_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_out_client) && $stable(rsp_out_elderly) && $stable(rsp_last))
      else $error("result changed while stalled");

   // the block is busy right after taking a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

   // error results carry no client
   a_err_no_client: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_out_client == '0 && !rsp_out_elderly)
      else $error("error result carries a client");

   // error results are always the only result of their request
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_last)
      else $error("error result not marked last");

endmodule

bind two_class_weighted_priority_queue wpq_props #(.ID_WIDTH(ID_WIDTH)) u_wpq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_out_client  (rsp_out_client),
   .rsp_out_elderly (rsp_out_elderly),
   .rsp_last        (rsp_last)
);
